// File: rtl/core/price_level_order_book_unit_macros.svh
// Assertion macros used by price_level_order_book_unit.sv.
`ifndef PRICE_LEVEL_ORDER_BOOK_UNIT_MACROS_SVH
`define PRICE_LEVEL_ORDER_BOOK_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLOB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PLOB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/plob_pkg.sv
package plob_pkg;

    localparam int LEVELS_DEF     = 256;
    localparam int PRICE_BITS_DEF = 20;
    localparam int MAX_DEPTH_DEF  = 32;

    localparam int FIELD_PRICE_W = 20;
    localparam int FIELD_IQTY_W  = 16;
    localparam int QTY_W         = 32;
    localparam int DEPTH_W       = 6;
    localparam int PADDR_W       = 3;

    localparam logic REG_BOOK_DEPTH = 1'b0;
    localparam logic REQ_ADD        = 1'b0;
    localparam logic REQ_REPORT     = 1'b1;
    localparam logic SIDE_SELL      = 1'b0;
    localparam logic SIDE_BUY       = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_SEL_SCAN,
        ST_BUY_OUT,
        ST_SELL_OUT,
        ST_MARKER
    } state_t;

endpackage

// File: rtl/core/plob_ram.sv
module plob_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 512,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/price_level_order_book_unit.sv
// Add order: scans that side's levels; a matching price gains the quantity, else a new
// level is appended, or the overflow flag set if the side is full. Report: one full scan
// of the side per reported level; one request at a time, as in_ready is high only in idle.
// Both sides share one RAM with a registered read; results leave through a
// one-entry output register. Reset clears level counts, overflow flag and sets depth 1.
module price_level_order_book_unit #(
    parameter int LEVELS     = plob_pkg::LEVELS_DEF,
    parameter int PRICE_BITS = plob_pkg::PRICE_BITS_DEF,
    parameter int MAX_DEPTH  = plob_pkg::MAX_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 req_type,
    input  logic                                 order_side,
    input  logic [plob_pkg::FIELD_PRICE_W-1:0]   order_price,
    input  logic [plob_pkg::FIELD_IQTY_W-1:0]    order_qty,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 level_side,
    output logic [plob_pkg::FIELD_PRICE_W-1:0]   level_price,
    output logic [plob_pkg::QTY_W-1:0]           level_qty,
    output logic                                 is_last,
    output logic                                 no_levels,
    output logic                                 overflow_seen,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [plob_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import plob_pkg::*;

    `include "price_level_order_book_unit_macros.svh"

    localparam int IW = $clog2(LEVELS);
    localparam int CW = IW + 1;
    localparam int NW = $clog2(MAX_DEPTH + 1);
    localparam int DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int MW = (CW > DEPTH_W) ? CW : DEPTH_W;
    localparam int EW = PRICE_BITS + QTY_W;

    // Configuration port.
    logic [DEPTH_W-1:0] depth_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_BOOK_DEPTH) ? {{(32-DEPTH_W){1'b0}}, depth_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_W'(1);
        end
        else if (cfg_wr && paddr[2] == REG_BOOK_DEPTH)
        begin
            depth_reg <= pwdata[DEPTH_W-1:0];
        end
    end

    // Level table: both sides in one RAM, side selects the upper half.
    logic          ram_we;
    logic [IW:0]   ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW:0]   ram_raddr;
    logic [EW-1:0] ram_rdata;

    plob_ram #(
        .WIDTH(EW),
        .DEPTH(2 * LEVELS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    state_t                state_reg, state_next;
    logic [CW-1:0]         sell_cnt_reg, sell_cnt_next;
    logic [CW-1:0]         buy_cnt_reg, buy_cnt_next;
    logic                  ovf_reg, ovf_next;
    logic                  side_reg, side_next;
    logic [PRICE_BITS-1:0] add_price_reg, add_price_next;
    logic [FIELD_IQTY_W-1:0] add_qty_reg, add_qty_next;
    logic [CW-1:0]         scan_idx_reg, scan_idx_next;
    logic                  pend_reg, pend_next;
    logic [IW-1:0]         pend_idx_reg, pend_idx_next;
    logic                  best_valid_reg, best_valid_next;
    logic [PRICE_BITS-1:0] best_price_reg, best_price_next;
    logic [QTY_W-1:0]      best_qty_reg, best_qty_next;
    logic [PRICE_BITS-1:0] last_price_reg, last_price_next;
    logic [NW-1:0]         pass_reg, pass_next;
    logic [NW-1:0]         ns_reg, ns_next;
    logic [NW-1:0]         nb_reg, nb_next;
    logic [DW-1:0]         ptr_reg, ptr_next;
    logic [EW-1:0]         buf_reg [MAX_DEPTH];
    logic                  buf_we;

    logic                  ov_reg, ov_next;
    logic                  ov_side_reg, ov_side_next;
    logic [FIELD_PRICE_W-1:0] ov_price_reg, ov_price_next;
    logic [QTY_W-1:0]      ov_qty_reg, ov_qty_next;
    logic                  ov_last_reg, ov_last_next;
    logic                  ov_nolev_reg, ov_nolev_next;
    logic                  ov_ovf_reg, ov_ovf_next;

    logic [CW-1:0]         side_cnt;
    logic                  issue;
    logic                  scan_done;
    logic [PRICE_BITS-1:0] r_price;
    logic [QTY_W-1:0]      r_qty;
    logic [QTY_W:0]        sum;
    logic [DEPTH_W-1:0]    eff_depth;
    logic                  out_free;
    logic                  cand;
    logic [NW-1:0]         ns_m1;
    logic [EW-1:0]         buf_rd;

    assign side_cnt  = (side_reg == SIDE_BUY) ? buy_cnt_reg : sell_cnt_reg;
    assign r_price   = ram_rdata[EW-1:QTY_W];
    assign r_qty     = ram_rdata[QTY_W-1:0];
    assign sum       = {1'b0, r_qty} + (QTY_W + 1)'(add_qty_reg);
    assign out_free  = !ov_reg || out_ready;
    assign scan_done = (scan_idx_reg == side_cnt) && !pend_reg;
    assign issue     = (state_reg == ST_ADD_SCAN || state_reg == ST_SEL_SCAN)
                       && (scan_idx_reg < side_cnt);
    assign ram_raddr = {side_reg, scan_idx_reg[IW-1:0]};
    assign ns_m1     = ns_reg - NW'(1);
    assign buf_rd    = buf_reg[ptr_reg];
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        if (depth_reg == '0)
        begin
            eff_depth = DEPTH_W'(1);
        end
        else if (depth_reg > DEPTH_W'(MAX_DEPTH))
        begin
            eff_depth = DEPTH_W'(MAX_DEPTH);
        end
        else
        begin
            eff_depth = depth_reg;
        end
    end

    // Candidate for the current pass: past the previous pick and better than the best so far.
    always_comb
    begin
        if (side_reg == SIDE_SELL)
        begin
            cand = (pass_reg == '0 || r_price > last_price_reg)
                   && (!best_valid_reg || r_price < best_price_reg);
        end
        else
        begin
            cand = (pass_reg == '0 || r_price < last_price_reg)
                   && (!best_valid_reg || r_price > best_price_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sell_cnt_next   = sell_cnt_reg;
        buy_cnt_next    = buy_cnt_reg;
        ovf_next        = ovf_reg;
        side_next       = side_reg;
        add_price_next  = add_price_reg;
        add_qty_next    = add_qty_reg;
        scan_idx_next   = issue ? scan_idx_reg + CW'(1) : scan_idx_reg;
        pend_next       = issue;
        pend_idx_next   = scan_idx_reg[IW-1:0];
        best_valid_next = best_valid_reg;
        best_price_next = best_price_reg;
        best_qty_next   = best_qty_reg;
        last_price_next = last_price_reg;
        pass_next       = pass_reg;
        ns_next         = ns_reg;
        nb_next         = nb_reg;
        ptr_next        = ptr_reg;
        buf_we          = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = {side_reg, pend_idx_reg};
        ram_wdata       = {r_price, sum[QTY_W] ? {QTY_W{1'b1}} : sum[QTY_W-1:0]};
        ov_next         = ov_reg && !out_ready;
        ov_side_next    = ov_side_reg;
        ov_price_next   = ov_price_reg;
        ov_qty_next     = ov_qty_reg;
        ov_last_next    = ov_last_reg;
        ov_nolev_next   = ov_nolev_reg;
        ov_ovf_next     = ov_ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                scan_idx_next   = '0;
                best_valid_next = 1'b0;
                pass_next       = '0;
                if (in_valid)
                begin
                    if (req_type == REQ_ADD)
                    begin
                        side_next      = order_side;
                        add_price_next = PRICE_BITS'(order_price);
                        add_qty_next   = order_qty;
                        state_next     = ST_ADD_SCAN;
                    end
                    else
                    begin
                        ns_next = (MW'(sell_cnt_reg) < MW'(eff_depth)) ?
                                  NW'(sell_cnt_reg) : NW'(eff_depth);
                        nb_next = (MW'(buy_cnt_reg) < MW'(eff_depth)) ?
                                  NW'(buy_cnt_reg) : NW'(eff_depth);
                        if (sell_cnt_reg != '0)
                        begin
                            side_next  = SIDE_SELL;
                            state_next = ST_SEL_SCAN;
                        end
                        else if (buy_cnt_reg != '0)
                        begin
                            side_next  = SIDE_BUY;
                            state_next = ST_SEL_SCAN;
                        end
                        else
                        begin
                            state_next = ST_MARKER;
                        end
                    end
                end
            end

            ST_ADD_SCAN:
            begin
                if (pend_reg && r_price == add_price_reg)
                begin
                    ram_we     = 1'b1;
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (scan_done)
                begin
                    state_next = ST_IDLE;
                    if (side_cnt < CW'(LEVELS))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = {side_reg, side_cnt[IW-1:0]};
                        ram_wdata = {add_price_reg, QTY_W'(add_qty_reg)};
                        if (side_reg == SIDE_BUY)
                        begin
                            buy_cnt_next = buy_cnt_reg + CW'(1);
                        end
                        else
                        begin
                            sell_cnt_next = sell_cnt_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end

            ST_SEL_SCAN:
            begin
                if (pend_reg && cand)
                begin
                    best_valid_next = 1'b1;
                    best_price_next = r_price;
                    best_qty_next   = r_qty;
                end
                if (scan_done)
                begin
                    last_price_next = best_price_reg;
                    if (side_reg == SIDE_SELL)
                    begin
                        buf_we          = 1'b1;
                        scan_idx_next   = '0;
                        best_valid_next = 1'b0;
                        if (pass_reg + NW'(1) == ns_reg)
                        begin
                            ptr_next   = ns_m1[DW-1:0];
                            state_next = ST_SELL_OUT;
                        end
                        else
                        begin
                            pass_next = pass_reg + NW'(1);
                        end
                    end
                    else
                    begin
                        state_next = ST_BUY_OUT;
                    end
                end
            end

            ST_BUY_OUT:
            begin
                if (out_free)
                begin
                    ov_next         = 1'b1;
                    ov_side_next    = SIDE_BUY;
                    ov_price_next   = FIELD_PRICE_W'(best_price_reg);
                    ov_qty_next     = best_qty_reg;
                    ov_last_next    = (pass_reg + NW'(1) == nb_reg);
                    ov_nolev_next   = 1'b0;
                    ov_ovf_next     = ovf_reg;
                    scan_idx_next   = '0;
                    best_valid_next = 1'b0;
                    pass_next       = pass_reg + NW'(1);
                    state_next      = (pass_reg + NW'(1) == nb_reg) ? ST_IDLE : ST_SEL_SCAN;
                end
            end

            ST_SELL_OUT:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    ov_side_next  = SIDE_SELL;
                    ov_price_next = FIELD_PRICE_W'(buf_rd[EW-1:QTY_W]);
                    ov_qty_next   = buf_rd[QTY_W-1:0];
                    ov_last_next  = (ptr_reg == '0) && (nb_reg == '0);
                    ov_nolev_next = 1'b0;
                    ov_ovf_next   = ovf_reg;
                    if (ptr_reg == '0)
                    begin
                        scan_idx_next   = '0;
                        best_valid_next = 1'b0;
                        pass_next       = '0;
                        side_next       = SIDE_BUY;
                        state_next      = (nb_reg == '0) ? ST_IDLE : ST_SEL_SCAN;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - DW'(1);
                    end
                end
            end

            ST_MARKER:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    ov_side_next  = SIDE_SELL;
                    ov_price_next = '0;
                    ov_qty_next   = '0;
                    ov_last_next  = 1'b1;
                    ov_nolev_next = 1'b1;
                    ov_ovf_next   = ovf_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sell_cnt_reg <= '0;
            buy_cnt_reg  <= '0;
            ovf_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sell_cnt_reg <= sell_cnt_next;
            buy_cnt_reg  <= buy_cnt_next;
            ovf_reg      <= ovf_next;
            pend_reg     <= pend_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg       <= side_next;
        add_price_reg  <= add_price_next;
        add_qty_reg    <= add_qty_next;
        scan_idx_reg   <= scan_idx_next;
        pend_idx_reg   <= pend_idx_next;
        best_valid_reg <= best_valid_next;
        best_price_reg <= best_price_next;
        best_qty_reg   <= best_qty_next;
        last_price_reg <= last_price_next;
        pass_reg       <= pass_next;
        ns_reg         <= ns_next;
        nb_reg         <= nb_next;
        ptr_reg        <= ptr_next;
        ov_side_reg    <= ov_side_next;
        ov_price_reg   <= ov_price_next;
        ov_qty_reg     <= ov_qty_next;
        ov_last_reg    <= ov_last_next;
        ov_nolev_reg   <= ov_nolev_next;
        ov_ovf_reg     <= ov_ovf_next;
        if (buf_we)
        begin
            buf_reg[pass_reg[DW-1:0]] <= {best_price_reg, best_qty_reg};
        end
    end

    assign out_valid     = ov_reg;
    assign level_side    = ov_side_reg;
    assign level_price   = ov_price_reg;
    assign level_qty     = ov_qty_reg;
    assign is_last       = ov_last_reg;
    assign no_levels     = ov_nolev_reg;
    assign overflow_seen = ov_ovf_reg;

    `PLOB_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1,
        sell_cnt_reg <= CW'(LEVELS) && buy_cnt_reg <= CW'(LEVELS))
    `PLOB_ASSERT_NEXT(a_ovf_sticky, clk, rst_n, ovf_reg, ovf_reg)
    `PLOB_ASSERT_SAME(a_marker_last, clk, rst_n, ov_reg && ov_nolev_reg,
        ov_last_reg && ov_qty_reg == '0)
    `PLOB_ASSERT_SAME(a_pend_in_scan, clk, rst_n, pend_reg,
        state_reg == ST_ADD_SCAN || state_reg == ST_SEL_SCAN || state_reg == ST_IDLE
        || state_reg == ST_BUY_OUT || state_reg == ST_SELL_OUT)

endmodule

// File: test/price_level_order_book_unit_tb.sv
`timescale 1ns / 1ps

module price_level_order_book_unit_tb;
    import plob_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 2 * LEVELS_DEF + 40;

    typedef struct packed {
        logic                     side;
        logic [FIELD_PRICE_W-1:0] price;
        logic [QTY_W-1:0]         qty;
        logic                     is_last;
        logic                     no_levels;
        logic                     overflow;
    } level_report_t;

    class book_scoreboard;
        level_report_t            levels_due[$];
        logic [FIELD_PRICE_W-1:0] price_tab[2][LEVELS_DEF];
        logic [QTY_W-1:0]         qty_tab[2][LEVELS_DEF];
        int                       level_cnt[2];
        bit                       overflow;
        int                       depth = 1;
        int                       errors;
        int                       checked;
        int                       reports;

        function void push_level(bit sd, logic [FIELD_PRICE_W-1:0] pr, logic [QTY_W-1:0] q,
                                 bit nolev);
            level_report_t r;
            r.side = sd;
            r.price = pr;
            r.qty = q;
            r.is_last = 1'b0;
            r.no_levels = nolev;
            r.overflow = overflow;
            levels_due.insert(levels_due.size(), r);
        endfunction

        function void add_order(bit sd, logic [FIELD_PRICE_W-1:0] pr, logic [15:0] q);
            logic [32:0] sum;
            for (int j = 0; j < level_cnt[sd]; j++)
            begin
                if (price_tab[sd][j] == pr)
                begin
                    sum = {1'b0, qty_tab[sd][j]} + 33'(q);
                    qty_tab[sd][j] = sum[32] ? '1 : sum[31:0];
                    return;
                end
            end
            if (level_cnt[sd] >= LEVELS_DEF)
            begin
                overflow = 1'b1;
                return;
            end
            price_tab[sd][level_cnt[sd]] = pr;
            qty_tab[sd][level_cnt[sd]] = 32'(q);
            level_cnt[sd]++;
        endfunction

        function void note_request(bit rt, bit sd, logic [FIELD_PRICE_W-1:0] pr,
                                   logic [15:0] q);
            int d;
            int n;
            int best;
            int start;
            int picked[MAX_DEPTH_DEF];
            bit bound;
            logic [FIELD_PRICE_W-1:0] last;
            if (rt == REQ_ADD)
            begin
                add_order(sd, pr, q);
                return;
            end
            reports++;
            start = levels_due.size();
            d = (depth == 0) ? 1 : (depth > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : depth;
            // Sell levels are chosen lowest first but leave highest first.
            n = 0;
            bound = 0;
            last = '0;
            for (int i = 0; i < d; i++)
            begin
                best = -1;
                for (int j = 0; j < level_cnt[0]; j++)
                begin
                    if (bound && price_tab[0][j] <= last)
                        continue;
                    if (best < 0 || price_tab[0][j] < price_tab[0][best])
                        best = j;
                end
                if (best < 0)
                    break;
                picked[n] = best;
                n++;
                last = price_tab[0][best];
                bound = 1;
            end
            while (n > 0)
            begin
                n--;
                push_level(SIDE_SELL, price_tab[0][picked[n]], qty_tab[0][picked[n]], 0);
            end
            bound = 0;
            for (int i = 0; i < d; i++)
            begin
                best = -1;
                for (int j = 0; j < level_cnt[1]; j++)
                begin
                    if (bound && price_tab[1][j] >= last)
                        continue;
                    if (best < 0 || price_tab[1][j] > price_tab[1][best])
                        best = j;
                end
                if (best < 0)
                    break;
                push_level(SIDE_BUY, price_tab[1][best], qty_tab[1][best], 0);
                last = price_tab[1][best];
                bound = 1;
            end
            if (levels_due.size() == start)
                push_level(SIDE_SELL, '0, '0, 1);
            levels_due[levels_due.size() - 1].is_last = 1'b1;
        endfunction

        function void compare(string fname, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname,
                         exp_v, got_v);
            end
        endfunction

        function void check_result(level_report_t got);
            level_report_t e;
            if (levels_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected level, expected none, actual %0h", $time, got);
                return;
            end
            e = levels_due.pop_front();
            checked++;
            compare("level_side", 32'(e.side), 32'(got.side));
            compare("level_price", 32'(e.price), 32'(got.price));
            compare("level_qty", e.qty, got.qty);
            compare("is_last", 32'(e.is_last), 32'(got.is_last));
            compare("no_levels", 32'(e.no_levels), 32'(got.no_levels));
            compare("overflow_seen", 32'(e.overflow), 32'(got.overflow));
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     req_type = 1'b0;
    logic                     order_side = 1'b0;
    logic [FIELD_PRICE_W-1:0] order_price = '0;
    logic [FIELD_IQTY_W-1:0]  order_qty = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b1;
    logic                     level_side;
    logic [FIELD_PRICE_W-1:0] level_price;
    logic [QTY_W-1:0]         level_qty;
    logic                     is_last;
    logic                     no_levels;
    logic                     overflow_seen;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    book_scoreboard sb = new;
    bit quiet;
    int stall_left;
    int cycles;
    int requests_sent;

    price_level_order_book_unit dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({level_side, level_price, level_qty, is_last, no_levels,
                             overflow_seen});
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 15);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send(bit rt, bit sd, logic [FIELD_PRICE_W-1:0] pr, logic [15:0] q);
        int gap;
        in_valid <= 1'b1;
        req_type <= rt;
        order_side <= sd;
        order_price <= pr;
        order_qty <= q;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(rt, sd, pr, q);
        requests_sent++;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_report();
        send(REQ_REPORT, 1'($urandom_range(0, 1)), FIELD_PRICE_W'($urandom), 16'($urandom));
    endtask

    // The block may still be scanning after an order, which produces no result.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.levels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_depth(logic [31:0] v);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * REG_BOOK_DEPTH);
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.depth = v & 32'h3f;
        @(posedge clk);
    endtask

    task automatic random_phase(int count);
        logic [FIELD_PRICE_W-1:0] pr;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 15)
                send_report();
            else
            begin
                pr = ($urandom_range(0, 4) == 0) ? FIELD_PRICE_W'($urandom)
                                                  : FIELD_PRICE_W'(20'h01000 + $urandom_range(0, 40));
                send(REQ_ADD, 1'($urandom_range(0, 1)), pr, 16'($urandom));
            end
        end
    endtask

    initial
    begin
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty book at the reset depth gives the marker.
        send_report();
        send(REQ_ADD, SIDE_SELL, '0, '0);
        send_report();
        send(REQ_ADD, SIDE_BUY, '1, '1);
        send(REQ_ADD, SIDE_BUY, '1, '1);
        send_report();

        write_depth(32'hffff_ffc0);
        send(REQ_ADD, SIDE_SELL, '1, 16'h0001);
        send(REQ_ADD, SIDE_SELL, 20'h00001, 16'h8000);
        send(REQ_ADD, SIDE_BUY, '0, 16'h7fff);
        send(REQ_ADD, SIDE_BUY, 20'h55555, 16'h5555);
        send(REQ_ADD, SIDE_SELL, 20'haaaaa, 16'haaaa);
        send_report();
        write_depth(32'd63);
        send_report();

        write_depth(32'd1);
        random_phase(6);
        write_depth(32'd32);
        random_phase(6);
        write_depth(32'd3);
        random_phase(6);
        write_depth($urandom_range(0, 63));
        random_phase(6);

        // Fill the sell table, then send new prices that set overflow and a price already stored.
        quiet = 1;
        write_depth(32'd32);
        k = 0;
        while (sb.level_cnt[0] < LEVELS_DEF)
        begin
            send(REQ_ADD, SIDE_SELL, FIELD_PRICE_W'(20'h80000 + k), 16'($urandom));
            k++;
        end
        send_report();
        send(REQ_ADD, SIDE_SELL, 20'hfff00, 16'($urandom));
        send(REQ_ADD, SIDE_SELL, 20'h00002, 16'($urandom));
        send(REQ_ADD, SIDE_SELL, 20'h80000, 16'($urandom));
        send_report();
        write_depth(32'd5);
        send(REQ_ADD, SIDE_BUY, 20'h7ffff, 16'($urandom));
        send_report();
        drain();

        $display("Sent %0d requests including %0d reports; %0d levels checked.",
                 requests_sent, sb.reports, sb.checked);
        $display("Covered the empty-book marker, depth clamping and a full sell table.");
        if (sb.errors == 0 && sb.levels_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
